// ----- rtl/core/scs_pkg.sv -----
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types, character constants and the per-byte lexer function of the
// SQL comment stripper.
// ----------------------------------------------------------------------------
package scs_pkg;

   // Lexer modes
   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_STRING = 2'd1,
      MODE_LINE   = 2'd2,
      MODE_BLOCK  = 2'd3
   } lex_mode_type;

   // Characters the lexer looks for
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_DASH    = 8'h2D;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;

   // One result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       run_end;
      logic       query_done;
   } result_type;

   // Outcome of lexing one byte
   typedef struct packed {
      lex_mode_type mode;
      logic         dq;
      logic         emit;
      logic [7:0]   data;
      logic         eat;
   } lex_out_type;

   // Lex byte c with raw predecessor p and lookahead n (valid if has_next)
   function automatic lex_out_type scs_lex(lex_mode_type mode, logic dq,
                                           logic [7:0] c, logic [7:0] p,
                                           logic [7:0] n, logic has_next);
      lex_out_type r;
      logic        c_dq;
      r.mode = mode;
      r.dq   = dq;
      r.emit = 1'b0;
      r.data = c;
      r.eat  = 1'b0;
      c_dq   = (c == CH_DQUOTE);
      if (mode == MODE_NORMAL || mode == MODE_STRING) begin
         if ((c == CH_SQUOTE || c == CH_DQUOTE) && p != CH_BSLASH) begin
            // open a string, or close it on the matching quote
            if (mode != MODE_STRING) begin
               r.mode = MODE_STRING;
               r.dq   = c_dq;
            end else if (c_dq == dq) begin
               r.mode = MODE_NORMAL;
            end
            r.emit = 1'b1;
         end else if (mode == MODE_NORMAL && has_next &&
                      c == CH_DASH && n == CH_DASH) begin
            r.mode = MODE_LINE;
            r.eat  = 1'b1;
         end else if (mode == MODE_NORMAL && has_next &&
                      c == CH_SLASH && n == CH_STAR) begin
            r.mode = MODE_BLOCK;
            r.eat  = 1'b1;
         end else begin
            r.emit = 1'b1;
         end
      end else if (mode == MODE_LINE) begin
         // keep the newline that ends a line comment
         if (c == CH_NEWLINE) begin
            r.mode = MODE_NORMAL;
            r.emit = 1'b1;
         end
      end else if (has_next && c == CH_STAR && n == CH_SLASH) begin
         r.mode = MODE_NORMAL;
         r.eat  = 1'b1;
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/sql_comment_stripper_top.sv -----
// ----------------------------------------------------------------------------
// sql_comment_stripper_top
// Streaming SQL comment remover with one byte of lookahead.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one query byte per item, with req_end_of_query set
//   on the final byte. The rsp channel returns the query with '--' line
//   comments (ending newline kept) and block comments removed; quoted strings
//   pass unchanged. Each byte is held until the next byte arrives, so a kept
//   byte leaves one item later; the final byte of a query is judged alone.
//   An item causes zero, one or two result items; rsp_run_end marks the last
//   one of an item and rsp_query_done the last one of a query. A query whose
//   final item keeps no byte yields a bare marker with rsp_has_byte low.
//   Latency: a result is visible on rsp at the earliest in the cycle after the
//   item that causes it is accepted. Throughput: one item per cycle while
//   req_stall is low; the held and final bytes are lexed in the same cycle.
//   Results queue in a four-entry buffer; req_stall rises when fewer than two
//   entries are free, so a stalling receiver holds off the input once three
//   results wait, and the buffer never holds more than four. Reset clears
//   the lexer and empties the buffer.
// ----------------------------------------------------------------------------
module sql_comment_stripper_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_query,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_byte,
   output logic       rsp_run_end,
   output logic       rsp_query_done
);
   import scs_pkg::*;

   localparam int unsigned FifoDepth = 4;

   // lexer state
   lex_mode_type mode_ff, mode_in;
   logic         dq_ff, dq_in;
   logic [7:0]   held_ff, held_in;
   logic         held_vld_ff, held_vld_in;
   logic [7:0]   prev_ff, prev_in;
   logic         consumed_ff, consumed_in;

   // result buffer
   result_type   fifo_ff [FifoDepth];
   logic [1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [2:0]   count_ff, count_in;

   logic         req_take;
   logic         rsp_take;
   logic [7:0]   prev_of_in;
   lex_out_type  lex_held;
   lex_out_type  lex_last;
   logic         do_held;
   logic         do_last;
   lex_mode_type mode_mid;
   logic         dq_mid;
   result_type   res0, res1;
   logic [1:0]   res_cnt;

   assign req_stall = (count_ff > 3'd2);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_take  = rsp_valid && !rsp_stall;

   // Lex the held byte with the new byte as lookahead, then the final byte
   always_comb begin
      prev_of_in = held_vld_ff ? held_ff : 8'd0;
      do_held    = held_vld_ff && !consumed_ff;
      lex_held   = scs_lex(mode_ff, dq_ff, held_ff, prev_ff, req_in_byte, 1'b1);
      mode_mid   = do_held ? lex_held.mode : mode_ff;
      dq_mid     = do_held ? lex_held.dq : dq_ff;
      do_last    = req_end_of_query && !(do_held && lex_held.eat);
      lex_last   = scs_lex(mode_mid, dq_mid, req_in_byte, prev_of_in, 8'd0, 1'b0);
   end

   // Next lexer state
   always_comb begin
      mode_in     = mode_ff;
      dq_in       = dq_ff;
      held_in     = held_ff;
      held_vld_in = held_vld_ff;
      prev_in     = prev_ff;
      consumed_in = consumed_ff;
      if (req_take) begin
         if (req_end_of_query) begin
            // query over: back to reset values
            mode_in     = MODE_NORMAL;
            dq_in       = 1'b0;
            held_in     = 8'd0;
            held_vld_in = 1'b0;
            prev_in     = 8'd0;
            consumed_in = 1'b0;
         end else begin
            mode_in     = mode_mid;
            dq_in       = dq_mid;
            held_in     = req_in_byte;
            held_vld_in = 1'b1;
            prev_in     = prev_of_in;
            consumed_in = do_held && lex_held.eat;
         end
      end
   end

   // Result items caused by this item
   always_comb begin
      res0    = '0;
      res1    = '0;
      res_cnt = 2'd0;
      if (do_held && lex_held.emit) begin
         res0.out_byte = lex_held.data;
         res0.has_byte = 1'b1;
         res_cnt       = 2'd1;
      end
      if (req_end_of_query) begin
         if (do_last && lex_last.emit) begin
            if (res_cnt == 2'd0) begin
               res0.out_byte   = lex_last.data;
               res0.has_byte   = 1'b1;
               res0.run_end    = 1'b1;
               res0.query_done = 1'b1;
               res_cnt         = 2'd1;
            end else begin
               res1.out_byte   = lex_last.data;
               res1.has_byte   = 1'b1;
               res1.run_end    = 1'b1;
               res1.query_done = 1'b1;
               res_cnt         = 2'd2;
            end
         end else begin
            // bare end marker when nothing else closes the query
            res0.run_end    = 1'b1;
            res0.query_done = 1'b1;
            res_cnt         = 2'd1;
         end
      end else begin
         res0.run_end = (res_cnt != 2'd0);
      end
   end

   // Occupancy after push and pop
   always_comb begin
      count_in = count_ff;
      if (req_take) begin
         count_in = count_in + {1'b0, res_cnt};
      end
      if (rsp_take) begin
         count_in = count_in - 3'd1;
      end
   end

   // Advance lexer state and buffer pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_NORMAL;
         dq_ff       <= 1'b0;
         held_ff     <= 8'd0;
         held_vld_ff <= 1'b0;
         prev_ff     <= 8'd0;
         consumed_ff <= 1'b0;
         wr_ptr_ff   <= 2'd0;
         rd_ptr_ff   <= 2'd0;
         count_ff    <= 3'd0;
      end else begin
         mode_ff     <= mode_in;
         dq_ff       <= dq_in;
         held_ff     <= held_in;
         held_vld_ff <= held_vld_in;
         prev_ff     <= prev_in;
         consumed_ff <= consumed_in;
         count_ff    <= count_in;
         if (req_take) begin
            wr_ptr_ff <= wr_ptr_ff + res_cnt;
         end
         if (rsp_take) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
      end
   end

   // Write up to two results into the buffer
   always_ff @(posedge clock) begin
      if (req_take && res_cnt != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= res0;
      end
      if (req_take && res_cnt == 2'd2) begin
         fifo_ff[wr_ptr_ff + 2'd1] <= res1;
      end
   end

   // Head of buffer drives the result channel
   assign rsp_out_byte   = fifo_ff[rd_ptr_ff].out_byte;
   assign rsp_has_byte   = fifo_ff[rd_ptr_ff].has_byte;
   assign rsp_run_end    = fifo_ff[rd_ptr_ff].run_end;
   assign rsp_query_done = fifo_ff[rd_ptr_ff].query_done;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("result buffer over capacity");

   a_eoq_clears: assert property (@(posedge clock) disable iff (reset)
      req_take && req_end_of_query |=> mode_ff == MODE_NORMAL && !held_vld_ff)
      else $error("lexer state not cleared after end of query");

   a_eoq_result: assert property (@(posedge clock) disable iff (reset)
      req_take && req_end_of_query |=> count_ff != 3'd0)
      else $error("end of query produced no result");

   a_consumed_held: assert property (@(posedge clock) disable iff (reset)
      consumed_ff |-> held_vld_ff)
      else $error("consumed flag without a held byte");

   a_bare_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_byte |-> rsp_out_byte == 8'd0 && rsp_query_done)
      else $error("bare marker carries data or lacks query end");

endmodule
